FILE: rtl/pkrt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pkrt_pkg
// Shared types and constants for the priority keyed rule table.
// ----------------------------------------------------------------------------
package pkrt_pkg;

    // fixed widths of the channel fields
    localparam int FIELD_W  = 20;
    localparam int PRIO_W   = 20;
    localparam int STATUS_W = 2;

    typedef logic [FIELD_W-1:0]  field_t;
    typedef logic [PRIO_W-1:0]   prio_t;
    typedef logic [STATUS_W-1:0] status_t;

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    // result status codes
    localparam status_t ST_NEW       = 2'd0;
    localparam status_t ST_OVERWRITE = 2'd1;
    localparam status_t ST_KEPT      = 2'd2;
    localparam status_t ST_FULL      = 2'd3;

endpackage : pkrt_pkg
`default_nettype wire

FILE: rtl/pkrt_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pkrt_if
// Request and response channels of the rule table, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pkrt_req_if;
    logic                  valid;
    logic                  ready;
    logic                  cmd;
    pkrt_pkg::field_t      object_id;
    pkrt_pkg::field_t      attribute;
    pkrt_pkg::field_t      rule_value;
    pkrt_pkg::prio_t       priority_req;

    modport source (
        output valid, cmd, object_id, attribute, rule_value, priority_req,
        input  ready
    );
    modport sink (
        input  valid, cmd, object_id, attribute, rule_value, priority_req,
        output ready
    );
endinterface : pkrt_req_if

interface pkrt_rsp_if;
    logic                  valid;
    logic                  ready;
    pkrt_pkg::field_t      read_value;
    logic                  found;
    pkrt_pkg::status_t     status;

    modport source (
        output valid, read_value, found, status,
        input  ready
    );
    modport sink (
        input  valid, read_value, found, status,
        output ready
    );
endinterface : pkrt_rsp_if
`default_nettype wire

FILE: rtl/priority_keyed_rule_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// priority_keyed_rule_table
// Key/value table with priority resolved inserts, searched by a serial scan.
// ----------------------------------------------------------------------------
//  channel | dir | word
//  --------+-----+-----------------------------------------------------------
//  req     | in  | cmd, object_id, attribute, rule_value, priority_req
//  rsp     | out | read_value, found, status
//
//  a result is ready once the scan has read the entries up to a hit, or the
//  whole fill count on a miss; no new word is taken until that result is
//  registered. the single read port and one key comparator set this.
//  reset empties the table at once through the fill count; no clearing pass.
//  req is taken only between words; a held rsp word stalls the next result.
// ----------------------------------------------------------------------------
module priority_keyed_rule_table #(
    parameter int TABLE_DEPTH = 256,
    parameter int KEY_WIDTH   = 20,
    parameter int VALUE_WIDTH = 20
) (
    input  logic        clk,
    input  logic        rst_n,
    pkrt_req_if.sink    req,
    pkrt_rsp_if.source  rsp
);
    import pkrt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef logic [KEY_WIDTH-1:0]   key_t;
    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [IDX_W-1:0]       idx_t;
    typedef logic [CNT_W-1:0]       cnt_t;

    typedef struct packed {
        key_t   object_id;
        key_t   attribute;
        value_t rule_value;
        prio_t  priority_val;
    } entry_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE
    } state_t;

    entry_t mem [TABLE_DEPTH];

    state_t  state_reg;
    cnt_t    count_reg;
    cnt_t    issue_reg;
    idx_t    data_idx_reg;
    logic    pend_reg;
    logic    hit_reg;
    idx_t    hit_idx_reg;
    entry_t  rd_data_reg;
    prio_t   hit_prio_reg;
    value_t  hit_value_reg;

    logic    cmd_reg;
    key_t    obj_reg;
    key_t    attr_reg;
    value_t  val_reg;
    prio_t   pri_reg;

    logic    rsp_valid_reg;
    field_t  rsp_value_reg;
    logic    rsp_found_reg;
    status_t rsp_status_reg;

    logic    out_free;
    logic    key_match;
    logic    issue_more;
    logic    has_room;
    logic    wr_en;
    idx_t    wr_addr;
    entry_t  wr_data;

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = rsp_valid_reg;
    assign rsp.read_value = rsp_value_reg;
    assign rsp.found      = rsp_found_reg;
    assign rsp.status     = rsp_status_reg;

    assign out_free   = !rsp_valid_reg || rsp.ready;
    assign key_match  = pend_reg && (rd_data_reg.object_id == obj_reg)
                        && (rd_data_reg.attribute == attr_reg);
    assign issue_more = (issue_reg < count_reg);
    assign has_room   = (count_reg < CNT_W'(TABLE_DEPTH));

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = hit_idx_reg;
        wr_data = '{object_id: obj_reg, attribute: attr_reg,
                    rule_value: val_reg, priority_val: pri_reg};
        if (state_reg == S_DECIDE && out_free && cmd_reg == CMD_INSERT)
        begin
            if (hit_reg)
            begin
                wr_en = (pri_reg >= hit_prio_reg);
            end
            else
            begin
                wr_en   = has_room;
                wr_addr = count_reg[IDX_W-1:0];
            end
        end
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[issue_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            // in S_DECIDE the word is either held or replaced
            if (state_reg != S_DECIDE && rsp_valid_reg && rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        cmd_reg   <= req.cmd;
                        obj_reg   <= KEY_WIDTH'(req.object_id);
                        attr_reg  <= KEY_WIDTH'(req.attribute);
                        val_reg   <= VALUE_WIDTH'(req.rule_value);
                        pri_reg   <= req.priority_req;
                        issue_reg <= '0;
                        pend_reg  <= 1'b0;
                        hit_reg   <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                end

                S_SCAN:
                begin
                    // read data arrives in the cycle after its index is issued
                    pend_reg     <= issue_more;
                    data_idx_reg <= issue_reg[IDX_W-1:0];
                    if (issue_more)
                    begin
                        issue_reg <= issue_reg + cnt_t'(1);
                    end
                    if (key_match)
                    begin
                        hit_reg       <= 1'b1;
                        hit_idx_reg   <= data_idx_reg;
                        hit_prio_reg  <= rd_data_reg.priority_val;
                        hit_value_reg <= rd_data_reg.rule_value;
                        state_reg     <= S_DECIDE;
                    end
                    else if (!pend_reg && !issue_more)
                    begin
                        state_reg <= S_DECIDE;
                    end
                end

                S_DECIDE:
                begin
                    if (out_free)
                    begin
                        rsp_valid_reg <= 1'b1;
                        if (cmd_reg == CMD_QUERY)
                        begin
                            rsp_value_reg  <= hit_reg ? FIELD_W'(hit_value_reg) : '0;
                            rsp_found_reg  <= hit_reg;
                            rsp_status_reg <= ST_NEW;
                        end
                        else
                        begin
                            rsp_value_reg <= '0;
                            rsp_found_reg <= 1'b0;
                            if (hit_reg)
                            begin
                                rsp_status_reg <= (pri_reg >= hit_prio_reg) ?
                                                  ST_OVERWRITE : ST_KEPT;
                            end
                            else if (has_room)
                            begin
                                rsp_status_reg <= ST_NEW;
                                count_reg      <= count_reg + cnt_t'(1);
                            end
                            else
                            begin
                                rsp_status_reg <= ST_FULL;
                            end
                        end
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule : priority_keyed_rule_table
`default_nettype wire
